// File: sv/infix_expression_evaluator_core_assert.svh
// Assertion macros for the expression evaluator
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IEE_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define IEE_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define IEE_ASSERT_IMP(label, clk, rst_n, pre, post)
`define IEE_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: sv/iee_pkg.sv
package iee_pkg;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_POW   = 8'h5e;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam int NUM_VARS = 26;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_OPREAD, ST_OPWAIT, ST_EMIT, ST_EXEC, ST_CLOSE_DROP,
    ST_PUSHOP, ST_FINAL, ST_DONE
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_char;     // latch character and operand work
    logic op_read;       // issue operator stack top read
    logic op_pop;        // decrement operator count
    logic op_push;       // push latched character
    logic emit_top;      // send popped operator symbol, apply it
    logic emit_char;     // send latched operand symbol, push it
    logic emit_final;    // send final value, clear stacks
    logic alu_start;     // not used by the datapath; arithmetic starts after its own operand pops
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       op_empty;
    logic [7:0] op_top;
    logic       below_ok;   // an entry sits under the top
    logic [7:0] op_below;   // entry under the top
    logic       out_busy;   // output register full and held
    logic       alu_busy;
  } dp_sts_t;

  function automatic logic [2:0] prio(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd0;
    case (c)
      CH_PLUS, CH_MINUS: p = 3'd1;
      CH_MUL, CH_DIV:    p = 3'd2;
      CH_POW:            p = 3'd3;
      CH_OPEN, CH_CLOSE: p = 3'd4;
      default:           p = 3'd0;
    endcase
    return p;
  endfunction
endpackage

// File: sv/infix_expression_evaluator_core.sv
// channel | direction | fields
// in_     | input     | kind, var_index, var_value, symbol, last_symbol
// out_    | output    | kind, symbol, value, end_of_run
// A variable write is taken in the idle state; a character moves through operator
// stack reads (read, wait, emit), then per applied operator two operand pops and
// the ALU: add/sub resolve as soon as started, multiply, divide and power iterate.
// The ALU and the stack read port set the time a character takes.
// Reset clears counts, variable table and control; stack contents are not.
// An output stall holds the block before the next emitted beat.
module infix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [4:0]  in_var_index,
  input  logic [63:0] in_var_value,
  input  logic [7:0]  in_symbol,
  input  logic        in_last_symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_symbol,
  output logic [63:0] out_value,
  output logic        out_end_of_run
);
  import iee_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    var_we, last_res;

  iee_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_symbol(in_symbol), .in_last_symbol(in_last_symbol),
    .var_we(var_we), .last_res(last_res), .cmd(cmd), .sts(sts)
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_kind(in_kind),
    .in_var_index(in_var_index), .in_var_value(in_var_value), .in_symbol(in_symbol),
    .var_we(var_we), .last_res(last_res), .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_symbol(out_symbol), .out_value(out_value),
    .out_end_of_run(out_end_of_run)
  );
endmodule

// File: sv/iee_alu.sv
module iee_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [7:0]  op,
  input  logic [63:0] y,
  input  logic [63:0] x,
  output logic        busy,
  output logic        done,
  output logic [63:0] result
);
  import iee_pkg::*;

  typedef enum logic [2:0] {A_IDLE, A_DIV, A_SIGN, A_MUL, A_POW} alu_mode_t;

  alu_mode_t   mode_r, mode_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;     // quotient / multiplicand / power result
  logic [63:0] rem_r, rem_nxt;     // remainder / multiplier / base
  logic [63:0] aux_r, aux_nxt;     // divisor magnitude / exponent
  logic        neg_r, neg_nxt;
  logic        ph_r, ph_nxt;       // power: 0 multiply result, 1 square base
  logic [1:0]  mst_r, mst_nxt;     // partial product step
  logic [63:0] mp_r, mp_nxt;       // partial product sum
  logic [63:0] res_r, res_nxt;
  logic        done_r, done_nxt;
  logic [63:0] mag_y, mag_x, trial, ma, mprod, mfull;
  logic [31:0] mop_a, mop_b;
  logic [64:0] rsh;
  logic        mlast;

  assign mag_y = y[63] ? (64'd0 - y) : y;
  assign mag_x = x[63] ? (64'd0 - x) : x;
  assign rsh   = {rem_r, acc_r[63]};
  assign trial = rsh[63:0] - aux_r;

  // low 64 bits of ma * rem_r from three 32x32 products, one per cycle
  assign ma = (mode_r == A_POW && ph_r) ? rem_r : acc_r;
  always_comb begin
    case (mst_r)
      2'd0:    begin mop_a = ma[31:0];  mop_b = rem_r[31:0];  end
      2'd1:    begin mop_a = ma[63:32]; mop_b = rem_r[31:0];  end
      default: begin mop_a = ma[31:0];  mop_b = rem_r[63:32]; end
    endcase
  end
  assign mprod = mop_a * mop_b;
  assign mfull = mp_r + {mprod[31:0], 32'd0};
  assign mlast = (mst_r == 2'd2);

  // add/subtract at once; iterate restoring division, stepped multiply or square-and-multiply power
  always_comb begin
    mode_nxt = mode_r; cnt_nxt = cnt_r; acc_nxt = acc_r; rem_nxt = rem_r;
    aux_nxt = aux_r; neg_nxt = neg_r; ph_nxt = ph_r; res_nxt = res_r;
    mst_nxt = mst_r; mp_nxt = mp_r;
    done_nxt = 1'b0;
    unique case (mode_r)
      A_IDLE: begin
        if (start) begin
          mst_nxt = 2'd0;
          case (op)
            CH_PLUS:  begin res_nxt = y + x; done_nxt = 1'b1; end
            CH_MINUS: begin res_nxt = y - x; done_nxt = 1'b1; end
            CH_MUL:   begin acc_nxt = y; rem_nxt = x; mode_nxt = A_MUL; end
            CH_DIV: begin
              if (x == 64'd0) begin
                res_nxt = 64'd0; done_nxt = 1'b1;
              end else begin
                acc_nxt = mag_y; rem_nxt = 64'd0; aux_nxt = mag_x;
                neg_nxt = y[63] ^ x[63]; cnt_nxt = 7'd64; mode_nxt = A_DIV;
              end
            end
            default: begin
              if (x == 64'd0 || x[63]) begin
                res_nxt = 64'd1; done_nxt = 1'b1;
              end else begin
                acc_nxt = 64'd1; rem_nxt = y; aux_nxt = x; ph_nxt = 1'b0;
                mode_nxt = A_POW;
              end
            end
          endcase
        end
      end
      A_MUL: begin
        if (mlast) begin
          res_nxt = mfull; done_nxt = 1'b1; mode_nxt = A_IDLE; mst_nxt = 2'd0;
        end else begin
          mp_nxt = (mst_r == 2'd0) ? mprod : mfull;
          mst_nxt = mst_r + 2'd1;
        end
      end
      A_DIV: begin
        if (rsh[64] || rsh[63:0] >= aux_r) begin
          rem_nxt = trial; acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = rsh[63:0]; acc_nxt = {acc_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) mode_nxt = A_SIGN;
      end
      A_SIGN: begin
        res_nxt = neg_r ? (64'd0 - acc_r) : acc_r;
        done_nxt = 1'b1; mode_nxt = A_IDLE;
      end
      A_POW: begin
        if (!ph_r && mst_r == 2'd0 && aux_r == 64'd0) begin
          res_nxt = acc_r; done_nxt = 1'b1; mode_nxt = A_IDLE;
        end else if (!ph_r && mst_r == 2'd0 && !aux_r[0]) begin
          ph_nxt = 1'b1;
        end else if (mlast) begin
          mst_nxt = 2'd0;
          if (!ph_r) begin
            acc_nxt = mfull; ph_nxt = 1'b1;
          end else begin
            rem_nxt = mfull; aux_nxt = aux_r >> 1; ph_nxt = 1'b0;
          end
        end else begin
          mp_nxt = (mst_r == 2'd0) ? mprod : mfull;
          mst_nxt = mst_r + 2'd1;
        end
      end
      default: mode_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= A_IDLE; done_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt; aux_r <= aux_nxt;
    neg_r <= neg_nxt; ph_r <= ph_nxt; res_r <= res_nxt;
    mst_r <= mst_nxt; mp_r <= mp_nxt;
  end

  assign busy   = (mode_r != A_IDLE) || start;
  assign done   = done_r;
  assign result = res_r;
endmodule

// File: sv/iee_datapath.sv
`include "infix_expression_evaluator_core_assert.svh"
module iee_datapath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  iee_pkg::dp_cmd_t cmd,
  output iee_pkg::dp_sts_t sts,
  input  logic            in_kind,
  input  logic [4:0]      in_var_index,
  input  logic [63:0]     in_var_value,
  input  logic [7:0]      in_symbol,
  input  logic            var_we,
  input  logic            last_res,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_kind,
  output logic [7:0]      out_symbol,
  output logic [63:0]     out_value,
  output logic            out_end_of_run
);
  import iee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [7:0]  op_mem [STACK_DEPTH];
  logic [63:0] nd_mem [STACK_DEPTH];
  logic [63:0] var_r [NUM_VARS];
  logic [CW-1:0] opc_r, ndc_r;
  logic [7:0]  top_r, ch_r;
  logic [7:0]  below_r;
  logic        below_ok_r;
  logic [7:0]  aop_r;
  logic [63:0] rd_r;
  logic [63:0] x_r, y_r;
  logic [1:0]  pop_ph_r;
  logic        alu_run_r;
  logic        alu_busy, alu_done;
  logic [63:0] alu_res;
  logic        ov_r;
  logic        ok_r;
  logic [7:0]  os_r;
  logic [63:0] oval_r;
  logic        oend_r;
  logic [63:0] push_val;
  logic        push_en;
  logic [CW-1:0] ndc_nxt;

  // operator stack: registered top and next-below read
  always_ff @(posedge clk) begin
    if (cmd.op_push && opc_r < FULL) op_mem[opc_r[AW-1:0]] <= ch_r;
    if (cmd.op_read) begin
      top_r      <= op_mem[AW'(opc_r - CW'(1))];
      below_r    <= op_mem[AW'(opc_r - CW'(2))];
      below_ok_r <= (opc_r > CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) opc_r <= '0;
    else if (cmd.emit_final) opc_r <= '0;
    else if (cmd.op_push && opc_r < FULL) opc_r <= opc_r + CW'(1);
    else if (cmd.op_pop && opc_r != '0) opc_r <= opc_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) ch_r <= in_symbol;
  end

  // hold the operator being applied while the stack read moves on
  always_ff @(posedge clk) begin
    if (cmd.emit_top) aop_r <= top_r;
  end

  // variable table, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_VARS; i++) var_r[i] <= 64'd0;
    end else if (var_we && !in_kind && in_var_index < 5'(NUM_VARS)) begin
      var_r[in_var_index] <= in_var_value;
    end
  end

  // operand stack top, forwarding a push made in the same cycle
  always_ff @(posedge clk) begin
    if (push_en && ndc_r < FULL) rd_r <= push_val;
    else rd_r <= nd_mem[AW'(ndc_nxt - CW'(1))];
  end

  always_comb begin
    push_en  = 1'b0;
    push_val = 64'd0;
    ndc_nxt  = ndc_r;
    if (cmd.emit_char) begin
      push_en = 1'b1;
      push_val = (ch_r >= CH_A && ch_r <= CH_Z) ? var_r[5'(ch_r - CH_A)] : 64'd0;
    end else if (alu_done) begin
      push_en = 1'b1; push_val = alu_res;
    end
    if (cmd.emit_top && prio(top_r) != 3'd4 && ndc_r != '0) ndc_nxt = ndc_r - CW'(1);
    else if (pop_ph_r == 2'd1 && ndc_r != '0) ndc_nxt = ndc_r - CW'(1);
    else if (push_en && ndc_r < FULL) ndc_nxt = ndc_r + CW'(1);
    if (cmd.emit_final) ndc_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (push_en && ndc_r < FULL) nd_mem[ndc_r[AW-1:0]] <= push_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndc_r <= '0; pop_ph_r <= 2'd0; alu_run_r <= 1'b0;
    end else begin
      ndc_r <= ndc_nxt;
      alu_run_r <= 1'b0;
      if (cmd.emit_top && prio(top_r) != 3'd4) begin
        pop_ph_r <= 2'd1;
        x_r <= (ndc_r != '0) ? nd_mem[AW'(ndc_r - CW'(1))] : 64'd0;
      end else if (pop_ph_r == 2'd1) begin
        pop_ph_r <= 2'd2;
        y_r <= (ndc_r != '0) ? nd_mem[AW'(ndc_r - CW'(1))] : 64'd0;
      end else if (pop_ph_r == 2'd2) begin
        pop_ph_r <= 2'd0; alu_run_r <= 1'b1;
      end
    end
  end

  iee_alu u_alu (
    .clk(clk), .rst_n(rst_n), .start(alu_run_r), .op(aop_r), .y(y_r), .x(x_r),
    .busy(alu_busy), .done(alu_done), .result(alu_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit_top || cmd.emit_char || cmd.emit_final) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_top || cmd.emit_char) begin
      ok_r <= 1'b0; os_r <= cmd.emit_top ? top_r : ch_r; oval_r <= 64'd0; oend_r <= last_res;
    end else if (cmd.emit_final) begin
      ok_r <= 1'b1; os_r <= 8'd0; oval_r <= (ndc_r != '0) ? rd_r : 64'd0; oend_r <= 1'b1;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_symbol = os_r;
  assign out_value = oval_r;
  assign out_end_of_run = oend_r;

  assign sts.op_empty = (opc_r == '0);
  assign sts.op_top   = top_r;
  assign sts.below_ok = below_ok_r;
  assign sts.op_below = below_r;
  assign sts.out_busy = ov_r && out_stall;
  assign sts.alu_busy = alu_busy || (pop_ph_r != 2'd0) || alu_done || alu_run_r;

  `IEE_ASSERT_IMP(a_cnt_op, clk, rst_n, 1'b1, opc_r <= FULL)
  `IEE_ASSERT_IMP(a_cnt_nd, clk, rst_n, 1'b1, ndc_r <= FULL)
  `IEE_ASSERT_IMP(a_no_over, clk, rst_n, ov_r && out_stall, !(cmd.emit_top || cmd.emit_char || cmd.emit_final))
endmodule

// File: sv/iee_ctrl.sv
`include "infix_expression_evaluator_core_assert.svh"
module iee_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [7:0]       in_symbol,
  input  logic             in_last_symbol,
  output logic             var_we,
  output logic             last_res,
  output iee_pkg::dp_cmd_t cmd,
  input  iee_pkg::dp_sts_t sts
);
  import iee_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [7:0] ch_r;
  logic       last_r, last_nxt;
  logic       mode_r, mode_nxt; // 1 while flushing at end
  logic       acc;
  logic [2:0] pc;
  logic       gate;  // can emit: output free and arithmetic idle

  assign acc = in_valid && !in_stall;
  assign pc  = prio(ch_r);
  assign gate = !sts.out_busy && !sts.alu_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; last_r <= 1'b0; mode_r <= 1'b0;
    end else begin
      state_r <= state_nxt; last_r <= last_nxt; mode_r <= mode_nxt;
    end
    if (acc) ch_r <= in_symbol;
  end

  // sequence one character through the stacks
  always_comb begin
    state_nxt = state_r; last_nxt = last_r; mode_nxt = mode_r;
    cmd = '0; in_stall = 1'b1; var_we = 1'b0; last_res = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = sts.alu_busy;
        if (acc) begin
          var_we = !in_kind;
          if (in_kind) begin
            cmd.load_char = 1'b1; last_nxt = in_last_symbol; mode_nxt = 1'b0;
            state_nxt = ST_DISPATCH;
          end
        end
      end
      ST_DISPATCH: begin
        if (pc == 3'd0) begin
          if (gate) begin
            cmd.emit_char = 1'b1; last_res = !last_r;
            state_nxt = last_r ? ST_OPREAD : ST_IDLE; mode_nxt = last_r;
          end
        end else if (ch_r == CH_OPEN) begin
          state_nxt = ST_PUSHOP;
        end else begin
          state_nxt = ST_OPREAD;
        end
      end
      ST_OPREAD: begin
        if (sts.op_empty) begin
          state_nxt = mode_r ? ST_FINAL : (ch_r == CH_CLOSE ? ST_DONE : ST_PUSHOP);
        end else begin
          cmd.op_read = 1'b1; state_nxt = ST_OPWAIT;
        end
      end
      ST_OPWAIT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (mode_r) begin
          if (sts.op_top == CH_OPEN) begin
            cmd.op_pop = 1'b1; state_nxt = ST_OPREAD;
          end else if (gate) begin
            cmd.emit_top = 1'b1; cmd.op_pop = 1'b1; state_nxt = ST_OPREAD;
          end
        end else if (sts.op_top == CH_OPEN) begin
          state_nxt = (ch_r == CH_CLOSE) ? ST_CLOSE_DROP : ST_PUSHOP;
        end else if (ch_r != CH_CLOSE && prio(sts.op_top) < pc) begin
          state_nxt = ST_PUSHOP;
        end else if (gate) begin
          cmd.emit_top = 1'b1; cmd.op_pop = 1'b1; state_nxt = ST_OPREAD;
          // flag the beat when the entry below stops the pop loop
          last_res = !last_r && (!sts.below_ok || sts.op_below == CH_OPEN ||
                     (ch_r != CH_CLOSE && prio(sts.op_below) < pc));
        end
      end
      ST_CLOSE_DROP: begin
        cmd.op_pop = 1'b1; state_nxt = ST_DONE;
      end
      ST_PUSHOP: begin
        cmd.op_push = 1'b1; state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (last_r) begin
          mode_nxt = 1'b1; state_nxt = ST_OPREAD;
        end else if (!sts.alu_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (gate) begin
          cmd.emit_final = 1'b1; state_nxt = ST_IDLE; mode_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `IEE_ASSERT_NXT(a_acc_leaves, clk, rst_n, acc && in_kind, state_r == ST_DISPATCH)
  `IEE_ASSERT_IMP(a_final_gated, clk, rst_n, cmd.emit_final, !sts.out_busy && !sts.alu_busy)
  `IEE_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != ST_IDLE, in_stall)
endmodule

// File: tb/infix_expression_evaluator_core_tb.sv
module infix_expression_evaluator_core_tb;
  import iee_pkg::*;

  localparam int DEPTH = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    bit        kind;
    bit [7:0]  symbol;
    bit [63:0] value;
    bit        last;
  } token_beat_t;

  // Shunting-yard predictor plus queue of pending output beats
  class expr_scoreboard;
    bit [7:0]  op_stack[DEPTH];
    int        op_cnt;
    bit [63:0] num_stack[DEPTH];
    int        num_cnt;
    bit [63:0] vars[26];
    token_beat_t pending[$];
    token_beat_t step_out[$];
    int        errors;

    function int rank(bit [7:0] c);
      case (c)
        CH_PLUS, CH_MINUS: return 1;
        CH_MUL, CH_DIV:    return 2;
        CH_POW:            return 3;
        CH_OPEN, CH_CLOSE: return 4;
        default:           return 0;
      endcase
    endfunction

    function void push_num(bit [63:0] v);
      if (num_cnt < DEPTH) begin
        num_stack[num_cnt] = v;
        num_cnt++;
      end
    endfunction

    function bit [63:0] pop_num();
      if (num_cnt == 0) return 64'd0;
      num_cnt--;
      return num_stack[num_cnt];
    endfunction

    function bit [63:0] quotient(bit [63:0] y, bit [63:0] x);
      bit [63:0] my, mx, q;
      if (x == 0) return 64'd0;
      my = y[63] ? -y : y;
      mx = x[63] ? -x : x;
      q = my / mx;
      return (y[63] ^ x[63]) ? -q : q;
    endfunction

    function bit [63:0] power(bit [63:0] b, bit [63:0] e);
      bit [63:0] r;
      r = 64'd1;
      if (e == 0 || e[63]) return 64'd1;
      while (e != 0) begin
        if (e[0]) r = r * b;
        b = b * b;
        e = e >> 1;
      end
      return r;
    endfunction

    // Emit one postfix symbol and apply it to the operand stack
    function void emit(bit [7:0] c);
      token_beat_t t;
      bit [63:0] x, y, r;
      t.kind = 0; t.symbol = c; t.value = 0; t.last = 0;
      step_out.push_back(t);
      if (rank(c) == 0) begin
        if (c >= CH_A && c <= CH_Z) push_num(vars[c - CH_A]);
        else push_num(64'd0);
        return;
      end
      if (rank(c) == 4) return;
      x = pop_num();
      y = pop_num();
      case (c)
        CH_PLUS:  r = y + x;
        CH_MINUS: r = y - x;
        CH_MUL:   r = y * x;
        CH_DIV:   r = quotient(y, x);
        default:  r = power(y, x);
      endcase
      push_num(r);
    endfunction

    function bit [7:0] pop_op();
      op_cnt--;
      return op_stack[op_cnt];
    endfunction

    function void note_input(bit kind, bit [4:0] idx, bit [63:0] val, bit [7:0] c,
                             bit last);
      token_beat_t t;
      int p;
      bit [7:0] top;
      step_out.delete();
      if (!kind) begin
        if (idx < 26) vars[idx] = val;
        return;
      end
      p = rank(c);
      if (p == 0) begin
        emit(c);
      end else if (p < 4) begin
        while (op_cnt > 0 && op_stack[op_cnt-1] != CH_OPEN && rank(op_stack[op_cnt-1]) >= p)
          emit(pop_op());
        if (op_cnt < DEPTH) op_stack[op_cnt++] = c;
      end else if (c == CH_OPEN) begin
        if (op_cnt < DEPTH) op_stack[op_cnt++] = c;
      end else begin
        while (op_cnt > 0 && op_stack[op_cnt-1] != CH_OPEN) emit(pop_op());
        if (op_cnt > 0) op_cnt--;
      end
      if (last) begin
        while (op_cnt > 0) begin
          top = pop_op();
          if (top != CH_OPEN) emit(top);
        end
        t.kind = 1; t.symbol = 0; t.value = pop_num(); t.last = 0;
        step_out.push_back(t);
        op_cnt = 0;
        num_cnt = 0;
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
      foreach (step_out[i]) pending.push_back(step_out[i]);
    endfunction

    function void check_result(bit kind, bit [7:0] sym, bit [63:0] val, bit last);
      token_beat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat kind=%0b sym=%h value=%h end=%0b",
                 $time, kind, sym, val, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind != kind || e.symbol != sym || e.value != val || e.last != last) begin
        $display("%0t: mismatch expected kind=%0b sym=%h value=%h end=%0b", $time,
                 e.kind, e.symbol, e.value, e.last);
        $display("%0t:          actual   kind=%0b sym=%h value=%h end=%0b", $time,
                 kind, sym, val, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [4:0]  in_var_index;
  logic [63:0] in_var_value;
  logic [7:0]  in_symbol;
  logic        in_last_symbol;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [7:0]  out_symbol;
  logic [63:0] out_value;
  logic        out_end_of_run;

  expr_scoreboard sb;
  int send_idle;
  int recv_idle;
  int quiet_cycles;
  int items_sent;

  infix_expression_evaluator_core #(.STACK_DEPTH(DEPTH)) u_dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Randomly stall the result channel
  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < recv_idle);

  // Check accepted results
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_kind, out_symbol, out_value, out_end_of_run);

  // Count cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive one beat, holding it until accepted
  task automatic send_beat(bit kind, bit [4:0] idx, bit [63:0] val, bit [7:0] c, bit last);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_var_index = idx;
    in_var_value = val;
    in_symbol = c;
    in_last_symbol = last;
    do @(posedge clk); while (in_stall);
    sb.note_input(kind, idx, val, c, last);
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_var(bit [4:0] idx, bit [63:0] val);
    send_beat(1'b0, idx, val, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_beat(1'b1, 5'($urandom), {$urandom, $urandom}, s[i], i == s.len() - 1);
  endtask

  function automatic bit [7:0] pick_letter();
    return CH_A + 8'($urandom_range(0, 7));
  endfunction

  function automatic bit [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_MUL;
      3: return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Build and send one random well-formed expression
  task automatic send_expression();
    bit [7:0] toks[$];
    int depth;
    int terms;
    depth = 0;
    terms = $urandom_range(1, 6);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) toks.push_back(pick_operator());
      while ($urandom_range(0, 3) == 0 && depth < 4) begin
        toks.push_back(CH_OPEN);
        depth++;
      end
      toks.push_back(pick_letter());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        toks.push_back(CH_CLOSE);
        depth--;
      end
    end
    while (depth > 0) begin
      toks.push_back(CH_CLOSE);
      depth--;
    end
    foreach (toks[i])
      send_beat(1'b1, 5'($urandom), {$urandom, $urandom}, toks[i], i == toks.size() - 1);
  endtask

  // Random mix of writes, expressions and noise
  task automatic random_phase(int count);
    int stop;
    bit [63:0] v;
    stop = items_sent + count;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          v = ($urandom_range(0, 1)) ? {$urandom, $urandom} : 64'($signed($urandom_range(0, 10)) - 5);
          write_var(5'($urandom), v);
        end
        2: send_beat(1'b1, 5'($urandom), {$urandom, $urandom}, 8'($urandom), $urandom_range(0, 3) == 0);
        default: send_expression();
      endcase
    end
  endtask

  initial begin
    sb = new();
    send_idle = 0;
    recv_idle = 0;
    items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_var_index = '0;
    in_var_value = '0;
    in_symbol = '0;
    in_last_symbol = 1'b0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, every operator and the corner cases
    write_var(0, 64'h8000_0000_0000_0000);
    write_var(1, 64'hffff_ffff_ffff_ffff);
    write_var(3, 64'h7fff_ffff_ffff_ffff);
    write_var(4, 64'd3);
    write_var(31, 64'h1234);
    send_text("a/b");
    send_text("d/c");
    send_text("e^b");
    send_text("(e+d)*e-e^e");
    send_text(")+e");
    send_text("(e");
    send_text("#");
    send_text("+");

    // Hold off until every result has drained
    while (sb.pending.size() > 0) @(negedge clk);
    repeat (50) @(negedge clk);

    send_idle = 30; recv_idle = 49;
    random_phase(120);
    send_idle = 49; recv_idle = 30;
    random_phase(110);
    send_idle = 0; recv_idle = 0;
    random_phase(100);

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// File: infix_expression_evaluator_core.f
+incdir+sv
sv/iee_pkg.sv
sv/iee_alu.sv
sv/iee_datapath.sv
sv/iee_ctrl.sv
sv/infix_expression_evaluator_core.sv
tb/infix_expression_evaluator_core_tb.sv
